[rtl/ncc_pkg.sv]
// Shared constants and types for the nearest-centroid confusion counter.
package ncc_pkg;

  // Default sizes of the block.
  localparam int NUM_CLASSES_DEF = 6;
  localparam int AXIS_BITS_DEF   = 12;
  localparam int COUNT_BITS_DEF  = 16;

  // Centroid registers on the configuration port and the width of their index.
  localparam int NUM_CENTER_REGS = 6;
  localparam int CFG_IDX_W       = 3;

  // Item kinds carried on the input tuser bit.
  typedef enum logic {
    MODE_COUNT = 1'b0,
    MODE_CLEAR = 1'b1
  } mode_t;

  // Control from the pipeline to the counter store.
  typedef struct packed {
    logic rd_en;  // an item enters the update stage, so read its counter
    logic upd;    // the item in the update stage counts into a cell
    logic clr;    // the item in the update stage clears every counter
    logic adv;    // the item in the update stage moves on this cycle
  } cnt_ctl_t;

endpackage

[rtl/ncc_counts.sv]
// Confusion-matrix counter store with valid bits, bypass and saturating increment.
module ncc_counts
  import ncc_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  localparam int CELLS      = NUM_CLASSES * NUM_CLASSES,
  localparam int ADDR_W     = $clog2(CELLS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cnt_ctl_t              ctl,
  input  logic [ADDR_W-1:0]     rd_addr,
  input  logic [ADDR_W-1:0]     upd_addr,
  output logic [COUNT_BITS-1:0] cell_nxt
);

  logic [COUNT_BITS-1:0] mem [CELLS];
  logic [CELLS-1:0]      vld_r;
  logic [COUNT_BITS-1:0] rd_r;
  logic [COUNT_BITS-1:0] fwd_r;
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] old_cnt;
  logic                  wr_en;

  assign wr_en = ctl.adv && ctl.upd;

  // Current value of the cell being updated. A cell not written since the last
  // clear reads as zero; a write made in the same cycle as the read is bypassed.
  always_comb begin
    if (!vld_r[upd_addr]) begin
      old_cnt = '0;
    end else if (fwd_hit_r) begin
      old_cnt = fwd_r;
    end else begin
      old_cnt = rd_r;
    end
  end

  // Saturating increment.
  assign cell_nxt = (&old_cnt) ? old_cnt : old_cnt + COUNT_BITS'(1);

  // Counter memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[upd_addr] <= cell_nxt;
    end
    if (ctl.rd_en) begin
      rd_r  <= mem[rd_addr];
      fwd_r <= cell_nxt;
    end
  end

  // Bypass flag: set when the read hits the cell written at the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (ctl.rd_en) begin
      fwd_hit_r <= wr_en && (upd_addr == rd_addr);
    end
  end

  // Valid bits: cleared by reset and by a clear item, set by each write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv && ctl.clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[upd_addr] <= 1'b1;
    end
  end

endmodule

[rtl/nearest_centroid_confusion_count.sv]
// Nearest-centroid classifier with confusion-matrix counters: top level.
//
// Each classify item (tuser low) carries one x, y, z sample and its true class;
// the block finds the centroid with the smallest squared Euclidean distance
// (lowest index on a tie), adds one to the counter at row true class, column
// predicted class (saturating at all ones), and returns the predicted class,
// that distance and the new counter value. A clear item (tuser high) zeroes all
// counters and returns zeros; a true class beyond the class count is classified
// but counts nothing and reports a count of zero. One item is accepted every
// cycle unless the output stalls; each result passes through an input register,
// a register of all squared distances, the counter update stage (whose counter
// was read from memory one stage earlier, with a bypass for back-to-back hits
// on one cell) and the output register. Centroids reset to zero. The user must write
// them through the configuration port only while the block is idle; it is not enforced.
module nearest_centroid_confusion_count
  import ncc_pkg::*;
#(
  parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
  parameter int AXIS_BITS    = AXIS_BITS_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF,
  localparam int CLS_W       = $clog2(NUM_CLASSES),
  localparam int CTR_W       = 3 * AXIS_BITS,
  localparam int DIST_W      = 2 * AXIS_BITS + 2,
  localparam int IN_W        = 3 * AXIS_BITS + CLS_W,
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = CLS_W + DIST_W + COUNT_BITS,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CTR_W-1:0]       cfg_wdata,    // z, y, x from the top bits down
  // Input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // sample_x, sample_y, sample_z, true_class
  input  logic                   in_tuser,     // mode
  // Result items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata     // predicted_class, best_sq_dist, cell_count
);

  localparam int CELLS  = NUM_CLASSES * NUM_CLASSES;
  localparam int ADDR_W = $clog2(CELLS);

  // Centroid registers
  logic [CTR_W-1:0] center_r [NUM_CLASSES];

  // Input stage
  logic                 s1_v_r;
  mode_t                s1_mode_r;
  logic [AXIS_BITS-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic [CLS_W-1:0]     s1_truth_r;
  logic [DIST_W-1:0]    dist1 [NUM_CLASSES];

  // Distance stage
  logic                 s2_v_r;
  mode_t                s2_mode_r;
  logic [CLS_W-1:0]     s2_truth_r;
  logic [DIST_W-1:0]    s2_dist_r [NUM_CLASSES];
  logic [CLS_W-1:0]     best2;
  logic [DIST_W-1:0]    best_dist2;
  logic                 upd2;
  logic [ADDR_W-1:0]    addr2;

  // Update stage
  logic                 s3_v_r;
  mode_t                s3_mode_r;
  logic [CLS_W-1:0]     s3_pred_r;
  logic [DIST_W-1:0]    s3_dist_r;
  logic                 s3_upd_r;
  logic [ADDR_W-1:0]    s3_addr_r;
  logic [COUNT_BITS-1:0] cell_nxt;

  // Output stage
  logic                  out_v_r;
  logic [CLS_W-1:0]      out_pred_r;
  logic [DIST_W-1:0]     out_dist_r;
  logic [COUNT_BITS-1:0] out_cnt_r;

  // Handshake between stages
  logic     adv3, ready3, adv2, ready2, adv1, ready1;
  cnt_ctl_t cnt_ctl;

  assign adv3   = s3_v_r && (!out_v_r || out_tready);
  assign ready3 = !s3_v_r || adv3;
  assign adv2   = s2_v_r && ready3;
  assign ready2 = !s2_v_r || adv2;
  assign adv1   = s1_v_r && ready2;
  assign ready1 = !s1_v_r || adv1;

  assign in_tready = ready1;

  // Centroid writes; indexes past the centroid list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        center_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_CLASSES; k++) begin
        if (cfg_we && (k < NUM_CENTER_REGS) && (cfg_index == CFG_IDX_W'(k))) begin
          center_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ready1) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_tvalid) begin
      s1_mode_r  <= mode_t'(in_tuser);
      s1_x_r     <= in_tdata[AXIS_BITS-1:0];
      s1_y_r     <= in_tdata[2*AXIS_BITS-1:AXIS_BITS];
      s1_z_r     <= in_tdata[3*AXIS_BITS-1:2*AXIS_BITS];
      s1_truth_r <= in_tdata[IN_W-1:3*AXIS_BITS];
    end
  end

  // Squared distance to every centroid, in parallel.
  always_comb begin
    logic [AXIS_BITS-1:0]   cx, cy, cz, dx, dy, dz;
    logic [2*AXIS_BITS-1:0] qx, qy, qz;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      cx = center_r[k][AXIS_BITS-1:0];
      cy = center_r[k][2*AXIS_BITS-1:AXIS_BITS];
      cz = center_r[k][3*AXIS_BITS-1:2*AXIS_BITS];
      dx = (s1_x_r >= cx) ? s1_x_r - cx : cx - s1_x_r;
      dy = (s1_y_r >= cy) ? s1_y_r - cy : cy - s1_y_r;
      dz = (s1_z_r >= cz) ? s1_z_r - cz : cz - s1_z_r;
      qx = (2*AXIS_BITS)'(dx) * (2*AXIS_BITS)'(dx);
      qy = (2*AXIS_BITS)'(dy) * (2*AXIS_BITS)'(dy);
      qz = (2*AXIS_BITS)'(dz) * (2*AXIS_BITS)'(dz);
      dist1[k] = DIST_W'(qx) + DIST_W'(qy) + DIST_W'(qz);
    end
  end

  // Distance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (ready2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_mode_r  <= s1_mode_r;
      s2_truth_r <= s1_truth_r;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        s2_dist_r[k] <= dist1[k];
      end
    end
  end

  // Nearest centroid; a strict compare keeps the lowest index on a tie.
  always_comb begin
    best2      = '0;
    best_dist2 = s2_dist_r[0];
    for (int k = 1; k < NUM_CLASSES; k++) begin
      if (s2_dist_r[k] < best_dist2) begin
        best2      = CLS_W'(k);
        best_dist2 = s2_dist_r[k];
      end
    end
  end

  // Counter address of cell [true][predicted]; only classify items in range count.
  assign upd2  = (s2_mode_r == MODE_COUNT) && (int'(s2_truth_r) < NUM_CLASSES);
  assign addr2 = upd2 ? ADDR_W'(ADDR_W'(s2_truth_r) * ADDR_W'(NUM_CLASSES) + ADDR_W'(best2))
                      : '0;

  // Update stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (ready3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s3_mode_r <= s2_mode_r;
      s3_upd_r  <= upd2;
      s3_addr_r <= addr2;
      if (s2_mode_r == MODE_CLEAR) begin
        s3_pred_r <= '0;
        s3_dist_r <= '0;
      end else begin
        s3_pred_r <= best2;
        s3_dist_r <= best_dist2;
      end
    end
  end

  // Counter store
  assign cnt_ctl.rd_en = adv2;
  assign cnt_ctl.upd   = s3_upd_r;
  assign cnt_ctl.clr   = (s3_mode_r == MODE_CLEAR);
  assign cnt_ctl.adv   = adv3;

  ncc_counts #(
    .NUM_CLASSES (NUM_CLASSES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_counts (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cnt_ctl),
    .rd_addr  (addr2),
    .upd_addr (s3_addr_r),
    .cell_nxt (cell_nxt)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      out_pred_r <= s3_pred_r;
      out_dist_r <= s3_dist_r;
      out_cnt_r  <= s3_upd_r ? cell_nxt : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'({out_cnt_r, out_dist_r, out_pred_r});

endmodule

[test/nearest_centroid_confusion_count_test.sv]
// Self-checking testbench for the nearest-centroid confusion counter.
module nearest_centroid_confusion_count_test;
  import ncc_pkg::*;

  localparam int NCLS         = NUM_CLASSES_DEF;
  localparam int AXIS_W       = AXIS_BITS_DEF;
  localparam int CNT_W        = COUNT_BITS_DEF;
  localparam int CLS_W        = $clog2(NCLS);
  localparam int CTR_W        = 3 * AXIS_W;
  localparam int DIST_W       = 2 * AXIS_W + 2;
  localparam int IN_TDATA_W   = ((3 * AXIS_W + CLS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((CLS_W + DIST_W + CNT_W + 7) / 8) * 8;
  localparam int AXIS_MAX     = (1 << AXIS_W) - 1;
  localparam int SETTLE       = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int REPEAT_ITEMS = 60;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 310;

  typedef struct packed {
    mode_t              mode;
    logic [AXIS_W-1:0]  x;
    logic [AXIS_W-1:0]  y;
    logic [AXIS_W-1:0]  z;
    logic [CLS_W-1:0]   truth;
  } sample_item_t;

  typedef struct packed {
    logic [CLS_W-1:0]   cls;
    logic [DIST_W-1:0]  sq_dist;
    logic [CNT_W-1:0]   cnt;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CTR_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // sample_x, sample_y, sample_z, true_class
  logic                   in_tuser;   // mode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // predicted_class, best_sq_dist, cell_count

  // Predictor state: centroids as programmed and the confusion counters.
  logic [AXIS_W-1:0] ctr_x [NCLS];
  logic [AXIS_W-1:0] ctr_y [NCLS];
  logic [AXIS_W-1:0] ctr_z [NCLS];
  logic [CNT_W-1:0]  cell_counts [NCLS][NCLS];

  verdict_t     verdicts_due[$];
  sample_item_t last_sample;
  int           mismatches = 0;
  int           stalled_cycles = 0;
  bit           quiet_sender = 1'b0;
  bit           quiet_sink = 1'b0;
  bit           hold_off_req = 1'b0;

  nearest_centroid_confusion_count uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DIST_W-1:0] sq_diff(logic [AXIS_W-1:0] a, logic [AXIS_W-1:0] b);
    logic [DIST_W-1:0] diff;
    diff = (a >= b) ? a - b : b - a;
    return diff * diff;
  endfunction

  // Classifies one item against the current centroids and updates the counters.
  function automatic verdict_t classify_sample(sample_item_t s);
    verdict_t          v;
    logic [DIST_W-1:0] d;
    logic [DIST_W-1:0] best_d;
    int                best;
    v = '0;
    if (s.mode == MODE_CLEAR) begin
      for (int r = 0; r < NCLS; r++)
        for (int c = 0; c < NCLS; c++)
          cell_counts[r][c] = '0;
      return v;
    end
    best = 0;
    best_d = '0;
    for (int k = 0; k < NCLS; k++) begin
      d = sq_diff(s.x, ctr_x[k]) + sq_diff(s.y, ctr_y[k]) + sq_diff(s.z, ctr_z[k]);
      if (k == 0 || d < best_d) begin
        best_d = d;
        best = k;
      end
    end
    v.cls = CLS_W'(best);
    v.sq_dist = best_d;
    // A true class beyond the matrix is classified but counts nothing.
    if (s.truth < NCLS) begin
      if (cell_counts[s.truth][best] != '1) cell_counts[s.truth][best]++;
      v.cnt = cell_counts[s.truth][best];
    end
    return v;
  endfunction

  function automatic sample_item_t make_sample(mode_t m, int x, int y, int z, int truth);
    sample_item_t s;
    s.mode = m;
    s.x = AXIS_W'(x);
    s.y = AXIS_W'(y);
    s.z = AXIS_W'(z);
    s.truth = CLS_W'(truth);
    return s;
  endfunction

  function automatic logic [CTR_W-1:0] pack_xyz(int x, int y, int z);
    return {AXIS_W'(z), AXIS_W'(y), AXIS_W'(x)};
  endfunction

  function automatic logic [AXIS_W-1:0] jitter(logic [AXIS_W-1:0] c, int spread);
    int v;
    v = int'(c) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > AXIS_MAX) v = AXIS_MAX;
    return AXIS_W'(v);
  endfunction

  function automatic logic [AXIS_W-1:0] corner_axis();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return AXIS_W'($urandom_range(0, AXIS_MAX));
    endcase
  endfunction

  // Random traffic: mostly samples near a centroid with an in-range class.
  function automatic sample_item_t random_sample();
    sample_item_t s;
    int           r;
    int           k;
    r = $urandom_range(0, 99);
    if (r < 10) return last_sample;
    s.mode = MODE_COUNT;
    s.truth = ($urandom_range(0, 9) != 0) ? CLS_W'($urandom_range(0, NCLS - 1))
                                          : CLS_W'($urandom_range(NCLS, (1 << CLS_W) - 1));
    if (r < 13) begin
      s.mode = MODE_CLEAR;
      s.x = AXIS_W'($urandom_range(0, AXIS_MAX));
      s.y = AXIS_W'($urandom_range(0, AXIS_MAX));
      s.z = AXIS_W'($urandom_range(0, AXIS_MAX));
    end else if (r < 70) begin
      k = $urandom_range(0, NCLS - 1);
      s.x = jitter(ctr_x[k], 64);
      s.y = jitter(ctr_y[k], 64);
      s.z = jitter(ctr_z[k], 64);
    end else if (r < 88) begin
      s.x = AXIS_W'($urandom_range(0, AXIS_MAX));
      s.y = AXIS_W'($urandom_range(0, AXIS_MAX));
      s.z = AXIS_W'($urandom_range(0, AXIS_MAX));
    end else begin
      s.x = corner_axis();
      s.y = corner_axis();
      s.z = corner_axis();
    end
    return s;
  endfunction

  // Offers one item, waits for the handshake and records what it must produce.
  task automatic send_sample(input sample_item_t s);
    int gap;
    gap = quiet_sender ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= s.mode;
    in_tdata  <= IN_TDATA_W'({s.truth, s.z, s.y, s.x});
    do @(posedge clk); while (!in_tready);
    verdicts_due.push_back(classify_sample(s));
    last_sample = s;
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_centroid(input int idx, input logic [CTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    // Indexes past the centroid list are ignored by the block.
    if (idx < NUM_CENTER_REGS && idx < NCLS) begin
      ctr_x[idx] = value[0 +: AXIS_W];
      ctr_y[idx] = value[AXIS_W +: AXIS_W];
      ctr_z[idx] = value[2 * AXIS_W +: AXIS_W];
    end
  endtask

  // With every centroid at zero after reset, all distances tie and class 0 wins.
  task automatic test_reset_centroids();
    send_sample(make_sample(MODE_COUNT, 0, 0, 0, 0));
    send_sample(make_sample(MODE_COUNT, AXIS_MAX, AXIS_MAX, AXIS_MAX, 5));
    send_sample(make_sample(MODE_COUNT, AXIS_MAX, 0, 0, 6));
    send_sample(make_sample(MODE_COUNT, 123, 0, AXIS_MAX, 7));
    drain_results();
  endtask

  // Known centroids: exact hits, ties, far corners, out-of-range classes and a clear.
  task automatic test_directed();
    write_centroid(0, pack_xyz(0, 0, 0));
    write_centroid(1, pack_xyz(AXIS_MAX, AXIS_MAX, AXIS_MAX));
    write_centroid(2, pack_xyz(1000, 2000, 3000));
    write_centroid(3, pack_xyz(1000, 2000, 3000));
    write_centroid(4, pack_xyz(2000, 0, 0));
    write_centroid(5, pack_xyz(3000, 0, 0));
    send_sample(make_sample(MODE_COUNT, 0, 0, 0, 0));
    send_sample(make_sample(MODE_COUNT, 0, 0, 0, 0));
    send_sample(make_sample(MODE_COUNT, AXIS_MAX, AXIS_MAX, AXIS_MAX, 1));
    send_sample(make_sample(MODE_COUNT, 1000, 2000, 3000, 2));
    send_sample(make_sample(MODE_COUNT, 2500, 0, 0, 3));
    send_sample(make_sample(MODE_COUNT, 1000, 0, 0, 4));
    send_sample(make_sample(MODE_COUNT, AXIS_MAX, 0, 0, 5));
    send_sample(make_sample(MODE_COUNT, 0, AXIS_MAX, 0, 6));
    send_sample(make_sample(MODE_COUNT, 0, 0, AXIS_MAX, 7));
    send_sample(make_sample(MODE_CLEAR, AXIS_MAX, AXIS_MAX, AXIS_MAX, 7));
    send_sample(make_sample(MODE_COUNT, 0, 0, 0, 0));
    drain_results();
    // Writes past the list must leave every centroid alone.
    for (int idx = NUM_CENTER_REGS; idx < (1 << CFG_IDX_W); idx++)
      write_centroid(idx, '1);
    write_centroid(0, '1);
    send_sample(make_sample(MODE_COUNT, AXIS_MAX, AXIS_MAX, AXIS_MAX, 4));
    send_sample(make_sample(MODE_COUNT, 0, 0, 0, 2));
    send_sample(make_sample(MODE_COUNT, 3000, 0, 0, 5));
    drain_results();
  endtask

  // The receiver stops for a long stretch while items keep coming.
  task automatic test_backpressure();
    quiet_sender = 1'b1;
    hold_off_req = 1'b1;
    for (int n = 0; n < 40; n++) send_sample(random_sample());
    drain_results();
    quiet_sender = 1'b0;
  endtask

  // One cell is hit back to back many times, then cleared and hit again.
  task automatic test_repeated_cell();
    quiet_sender = 1'b1;
    quiet_sink = 1'b1;
    send_sample(make_sample(MODE_CLEAR, 0, 0, 0, 0));
    for (int n = 0; n < REPEAT_ITEMS; n++) send_sample(make_sample(MODE_COUNT, 17, 9, 4, 3));
    send_sample(make_sample(MODE_CLEAR, 0, 0, 0, 3));
    send_sample(make_sample(MODE_COUNT, 17, 9, 4, 3));
    drain_results();
    quiet_sender = 1'b0;
    quiet_sink = 1'b0;
  endtask

  // Several centroid settings, each followed by random traffic with varied pacing.
  task automatic test_random_phases();
    logic [CTR_W-1:0] base;
    for (int ph = 0; ph < PHASES; ph++) begin
      base = CTR_W'({$urandom(), $urandom()});
      for (int k = 0; k < NUM_CENTER_REGS; k++) begin
        case (ph)
          0: write_centroid(k, '0);
          1: write_centroid(k, '1);
          3: write_centroid(k, {jitter(base[2 * AXIS_W +: AXIS_W], 40),
                                jitter(base[AXIS_W +: AXIS_W], 40),
                                jitter(base[0 +: AXIS_W], 40)});
          default: write_centroid(k, CTR_W'({$urandom(), $urandom()}));
        endcase
      end
      write_centroid($urandom_range(NUM_CENTER_REGS, (1 << CFG_IDX_W) - 1),
                     CTR_W'({$urandom(), $urandom()}));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) begin
          quiet_sender = ($urandom_range(0, 3) == 0);
          quiet_sink = ($urandom_range(0, 3) == 0);
        end
        send_sample(random_sample());
      end
      drain_results();
    end
    quiet_sender = 1'b0;
    quiet_sink = 1'b0;
  endtask

  // Receiver pacing, with a long hold-off on request.
  initial begin : sink_pacing
    int n;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (quiet_sink) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic report_mismatch(input string what, input verdict_t want, input verdict_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected class %0d distance %0d count %0d, got class %0d distance %0d count %0d",
               what, want.cls, want.sq_dist, want.cnt, got.cls, got.sq_dist, got.cnt);
  endtask

  // Each accepted result is compared with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    verdict_t got;
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cls     = out_tdata[0 +: CLS_W];
      got.sq_dist = out_tdata[CLS_W +: DIST_W];
      got.cnt     = out_tdata[CLS_W + DIST_W +: CNT_W];
      if (verdicts_due.size() == 0) begin
        report_mismatch("unexpected result item", '0, got);
      end else begin
        want = verdicts_due.pop_front();
        if (got.cls !== want.cls || got.sq_dist !== want.sq_dist || got.cnt !== want.cnt)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("nearest_centroid_confusion_count verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    last_sample = '0;
    for (int k = 0; k < NCLS; k++) begin
      ctr_x[k] = '0;
      ctr_y[k] = '0;
      ctr_z[k] = '0;
      for (int c = 0; c < NCLS; c++) cell_counts[k][c] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_centroids();
    test_directed();
    test_backpressure();
    test_repeated_cell();
    test_random_phases();

    if (mismatches == 0) begin
      $display("nearest_centroid_confusion_count verification clean");
    end else begin
      $display("nearest_centroid_confusion_count verification failed");
    end
    $finish;
  end

endmodule

[nearest_centroid_confusion_count.f]
rtl/ncc_pkg.sv
rtl/ncc_counts.sv
rtl/nearest_centroid_confusion_count.sv
test/nearest_centroid_confusion_count_test.sv
